/* src/nnpo_pkg.sv */
// Package for the nearest-neighbor point order block.
// Coordinate types, cell link structs and register indexes. No dependencies.
package nnpo_pkg;

  localparam int COORD_W = 30;
  localparam int DIST_W  = 61;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Register indexes on the write port
  localparam logic CFG_HOME_X = 1'b0;
  localparam logic CFG_HOME_Y = 1'b1;

  // Point held in a cell of the chain
  typedef struct packed {
    logic   vld;
    coord_t x;
    coord_t y;
  } pt_t;

  // Absolute difference of two coordinates, used by the cell for the squared distance
  function automatic logic [COORD_W:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [COORD_W:0] d;
    begin
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      abs_diff = d[COORD_W] ? (COORD_W+1)'(-d) : (COORD_W+1)'(d);
    end
  endfunction

endpackage

/* src/nearest_neighbor_point_order_core.sv */
// Top level of the nearest-neighbor point order block.
// Chain of nnpo_cell plus a sequencer that scans the chain. Depends on nnpo_pkg.
//
//  channel | dir | beat contents
//  in_     | in  | tdata {point_y, point_x}, tlast = last_point
//  out_    | out | tdata {ordered_y, ordered_x}, tlast = end_of_order, tuser = overflow
//  cfg_    | in  | write enable, index, 30-bit data
//
// Loading takes one point per cycle. Ordering N points takes N rounds; round k runs
// the distance pipeline, takes slot k as the first candidate, compares one cell a
// cycle over the N-k-1 remaining cells, then has a swap step and an output step.
// Reset (rst_n, synchronous) empties the chain and returns to loading.
// A stalled out_ holds the ordering; in_ is not ready while ordering.
module nearest_neighbor_point_order_core
  import nnpo_pkg::*;
#(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // point_x [29:0], point_y [59:30]
  input  logic        in_tlast,   // last_point
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // ordered_x [29:0], ordered_y [59:30]
  output logic        out_tlast,  // end_of_order
  output logic        out_tuser,  // overflow
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [29:0] cfg_data
);

  localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    S_LOAD = 5'b00001,
    S_DIST = 5'b00010,
    S_SCAN = 5'b00100,
    S_SWAP = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  coord_t home_x_r, home_y_r, cur_x_r, cur_y_r;
  logic [CW-1:0] cnt_r, k_r, i_r, sel_r;
  logic [1:0] wait_r;
  logic drop_r;
  dist_t best_r;
  pt_t out_pt_r;
  logic out_last_r;

  pt_t   cell_q [MAX_POINTS];
  dist_t cell_d [MAX_POINTS];
  pt_t   cell_in [MAX_POINTS];
  logic  cell_ld [MAX_POINTS];

  logic in_acc, store;
  pt_t  in_pt;

  assign in_tready = (state_r == S_LOAD);
  assign in_acc = in_tvalid && in_tready;
  assign store  = in_acc && (cnt_r < CW'(MAX_POINTS));
  assign in_pt  = '{vld: 1'b1, x: coord_t'(in_tdata[29:0]), y: coord_t'(in_tdata[59:30])};

  // cell chain: loading writes each point into the slot given by count; swap
  // exchanges slot k with the selected one
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    always_comb begin
      cell_ld[g] = 1'b0;
      cell_in[g] = in_pt;
      if (store && cnt_r[IW-1:0] == IW'(g) && cnt_r < CW'(MAX_POINTS)) begin
        cell_ld[g] = 1'b1;
      end else if (state_r == S_SWAP && sel_r != k_r) begin
        if (k_r[IW-1:0] == IW'(g)) begin
          cell_ld[g] = 1'b1;
          cell_in[g] = cell_q[sel_r[IW-1:0]];
        end else if (sel_r[IW-1:0] == IW'(g)) begin
          cell_ld[g] = 1'b1;
          cell_in[g] = cell_q[k_r[IW-1:0]];
        end
      end
    end
    nnpo_cell u_cell (
      .clk(clk), .rst_n(rst_n), .clr(1'b0), .load(cell_ld[g]), .pt_in(cell_in[g]),
      .cur_x(cur_x_r), .cur_y(cur_y_r), .dist_en(state_r == S_DIST && wait_r == 2'd2),
      .pt_q(cell_q[g]), .dist_q(cell_d[g])
    );
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_LOAD: if (in_acc && in_tlast) state_nxt = (cnt_r == '0 && !store) ? S_LOAD : S_DIST;
      S_DIST: if (wait_r == 2'd2) state_nxt = S_SCAN;
      // first scan cycle only takes slot k as the candidate
      S_SCAN: if ((wait_r == 2'd3) ? (i_r >= cnt_r) : (i_r + 1'b1 >= cnt_r))
                state_nxt = S_SWAP;
      S_SWAP: state_nxt = S_OUT;
      S_OUT:  if (!out_tvalid || out_tready)
                state_nxt = (k_r + 1'b1 >= cnt_r) ? S_LOAD : S_DIST;
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r <= '0; k_r <= '0; i_r <= '0; sel_r <= '0; wait_r <= '0;
      drop_r <= 1'b0; out_tvalid <= 1'b0;
      home_x_r <= '0; home_y_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_index == CFG_HOME_X) home_x_r <= coord_t'(cfg_data);
      if (cfg_we && cfg_index == CFG_HOME_Y) home_y_r <= coord_t'(cfg_data);
      if (state_r == S_OUT && (!out_tvalid || out_tready)) out_tvalid <= 1'b1;
      else if (out_tready) out_tvalid <= 1'b0;
      case (state_r)
        S_LOAD: begin
          if (store) cnt_r <= cnt_r + 1'b1;
          if (in_acc && !store) drop_r <= 1'b1;
          if (in_acc && in_tlast) begin
            cur_x_r <= home_x_r; cur_y_r <= home_y_r;
            k_r <= '0; wait_r <= '0;
            if (cnt_r == '0 && !store) drop_r <= 1'b0;
          end
        end
        S_DIST: begin
          wait_r <= wait_r + 1'b1;
          i_r <= k_r + 1'b1; sel_r <= k_r;
          if (wait_r == 2'd2) best_r <= '1;
        end
        S_SCAN: begin
          if (wait_r == 2'd3) begin
            best_r <= cell_d[k_r[IW-1:0]];
            wait_r <= '0;
          end else if (i_r < cnt_r) begin
            if (cell_d[i_r[IW-1:0]] < best_r) begin
              best_r <= cell_d[i_r[IW-1:0]]; sel_r <= i_r;
            end
            i_r <= i_r + 1'b1;
          end
        end
        S_SWAP: begin
          out_pt_r <= cell_q[sel_r[IW-1:0]];
          cur_x_r <= cell_q[sel_r[IW-1:0]].x;
          cur_y_r <= cell_q[sel_r[IW-1:0]].y;
          out_last_r <= (k_r + 1'b1 >= cnt_r);
        end
        S_OUT: begin
          if (!out_tvalid || out_tready) begin
            k_r <= k_r + 1'b1; wait_r <= '0;
            if (k_r + 1'b1 >= cnt_r) begin
              cnt_r <= '0; drop_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_tvalid || out_tready)) begin
      out_tdata <= {4'b0, out_pt_r.y, out_pt_r.x};
      out_tlast <= out_last_r;
      out_tuser <= drop_r;
    end
  end

  // checks
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS)) else $error("count above capacity");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_LOAD |-> !in_tready) else $error("ready while ordering");
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SWAP |-> (sel_r >= k_r && sel_r < cnt_r)) else $error("bad selection");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_tvalid && !out_tready |=> state_r == S_OUT)
    else $error("advanced past a stalled beat");

endmodule

/* src/nnpo_cell.sv */
// One cell of the point chain: holds one stored point and its distance to the
// current position. Depends on nnpo_pkg.
module nnpo_cell
  import nnpo_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   clr,        // drop the held point
  input  logic   load,       // take the point on pt_in
  input  pt_t    pt_in,
  input  coord_t cur_x,
  input  coord_t cur_y,
  input  logic   dist_en,    // latch squared distance to the current position
  output pt_t    pt_q,
  output dist_t  dist_q
);

  pt_t             pt_r, pt_nxt;
  logic [COORD_W:0] dx_r, dy_r;
  logic [2*COORD_W+1:0] sq;

  // held point
  always_comb begin
    pt_nxt = pt_r;
    if (clr) pt_nxt.vld = 1'b0;
    else if (load) pt_nxt = pt_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pt_r.vld <= 1'b0;
    else        pt_r.vld <= pt_nxt.vld;
    pt_r.x <= pt_nxt.x;
    pt_r.y <= pt_nxt.y;
  end

  // distance: differences registered, then squares summed and registered
  assign sq = (2*COORD_W+2)'(dx_r * dx_r) + (2*COORD_W+2)'(dy_r * dy_r);

  always_ff @(posedge clk) begin
    dx_r   <= abs_diff(cur_x, pt_r.x);
    dy_r   <= abs_diff(cur_y, pt_r.y);
    if (dist_en) dist_q <= sq[DIST_W-1:0];
  end

  assign pt_q = pt_r;

endmodule

/* tb/sv/nearest_neighbor_point_order_core_tb.sv */
// Testbench for nearest_neighbor_point_order_core: loads point sets, predicts the
// nearest-neighbor visiting order and checks every out_ beat. Depends on nnpo_pkg.
`timescale 1ns / 100ps

module nearest_neighbor_point_order_core_tb;
  import nnpo_pkg::*;

  localparam int     NPTS    = 64;
  localparam coord_t CMAX    = 30'sh1FFFFFFF;
  localparam coord_t CMIN    = 30'sh20000000;
  localparam int     SETTLE  = 40;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     eoo;
    bit     ovf;
  } visit_t;

  typedef struct {
    coord_t x;
    coord_t y;
    bit     last;
    bit     typed;
    visit_t want;
  } row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_we = 0;
  logic        cfg_index = CFG_HOME_X;
  logic [29:0] cfg_data = '0;

  // predictor state
  coord_t home_x_q, home_y_q;
  coord_t pts_x[NPTS];
  coord_t pts_y[NPTS];
  int     pt_cnt;
  bit     dropped;
  visit_t visit_q[$];

  int  n_err, n_items, n_visits, n_sets, n_ovf_sets;
  bit  quiet;

  nearest_neighbor_point_order_core uut (.*);

  always #2 clk = ~clk;

  task automatic report(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    n_err++;
  endtask

  function automatic longint unsigned sq_dist(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  // Store one accepted point; on last, run the greedy order and queue the visits if emit is set
  task automatic order_point(input coord_t x, input coord_t y, input bit last, input bit emit);
    coord_t cx, cy, tx, ty;
    longint unsigned best, d;
    int sel;
    visit_t v;
    if (pt_cnt < NPTS) begin
      pts_x[pt_cnt] = x;
      pts_y[pt_cnt] = y;
      pt_cnt++;
    end else begin
      dropped = 1;
    end
    if (!last) return;
    cx = home_x_q;
    cy = home_y_q;
    for (int k = 0; k < pt_cnt; k++) begin
      best = sq_dist(cx, cy, pts_x[k], pts_y[k]);
      sel = k;
      for (int i = k + 1; i < pt_cnt; i++) begin
        d = sq_dist(cx, cy, pts_x[i], pts_y[i]);
        if (d < best) begin
          best = d;
          sel = i;
        end
      end
      tx = pts_x[k];
      ty = pts_y[k];
      pts_x[k] = pts_x[sel];
      pts_y[k] = pts_y[sel];
      pts_x[sel] = tx;
      pts_y[sel] = ty;
      cx = pts_x[k];
      cy = pts_y[k];
      v.x = cx;
      v.y = cy;
      v.eoo = (k + 1 == pt_cnt);
      v.ovf = dropped;
      if (emit) visit_q.push_back(v);
    end
    n_sets++;
    if (dropped) n_ovf_sets++;
    pt_cnt = 0;
    dropped = 0;
  endtask

  task automatic send_point(input coord_t x, input coord_t y, input bit last,
                            input bit emit);
    in_tdata  <= {4'b0, y, x};
    in_tlast  <= last;
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    order_point(x, y, last, emit);
    n_items++;
    quiet = (n_items >= 210);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Idle point: nothing pending, then let the block settle
  task automatic drain();
    in_tvalid <= 0;
    wait (visit_q.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_home(input coord_t hx, input coord_t hy);
    cfg_we    <= 1;
    cfg_index <= CFG_HOME_X;
    cfg_data  <= hx;
    @(posedge clk);
    cfg_index <= CFG_HOME_Y;
    cfg_data  <= hy;
    @(posedge clk);
    cfg_we    <= 0;
    home_x_q = hx;
    home_y_q = hy;
  endtask

  function automatic coord_t pick_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 6)) - 3);
      default: begin
        case ($urandom_range(0, 3))
          0: return CMAX;
          1: return CMIN;
          2: return '0;
          default: return coord_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_set(input int size, input int mode);
    for (int i = 0; i < size; i++)
      send_point(pick_coord(mode), pick_coord(mode), i == size - 1, 1);
  endtask

  // out_ checker, samples pre-edge values
  always @(posedge clk) begin
    visit_t w;
    if (rst_n && out_tvalid && out_tready) begin
      n_visits++;
      if (visit_q.size() == 0) begin
        report($sformatf("unexpected beat %h/%b%b", out_tdata[59:0], out_tuser, out_tlast));
      end else begin
        w = visit_q.pop_front();
        if (coord_t'(out_tdata[29:0]) !== w.x)
          report($sformatf("x got %h want %h", out_tdata[29:0], w.x));
        if (coord_t'(out_tdata[59:30]) !== w.y)
          report($sformatf("y got %h want %h", out_tdata[59:30], w.y));
        if (out_tlast !== w.eoo)
          report($sformatf("end_of_order got %b want %b", out_tlast, w.eoo));
        if (out_tuser !== w.ovf)
          report($sformatf("overflow got %b want %b", out_tuser, w.ovf));
      end
    end
  end

  // out_tready: random stalls, one long hold-off to back up the input
  initial begin
    bit held;
    held = 0;
    wait (rst_n);
    forever begin
      if (!held && n_visits >= 30) begin
        held = 1;
        out_tready <= 0;
        repeat (400) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        out_tready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    #2ms;
    $display("[nearest_neighbor_point_order_core] ERROR");
    $finish;
  end

  // main sequence
  initial begin
    row_t rows[$];
    row_t r;
    int phase;
    home_x_q = '0;
    home_y_q = '0;
    pt_cnt   = 0;
    dropped  = 0;
    quiet    = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // single-point sets from reset home: the point itself comes back, flagged last
    rows.push_back('{'0, '0, 1, 1, '{'0, '0, 1, 0}});
    rows.push_back('{CMAX, CMIN, 1, 1, '{CMAX, CMIN, 1, 0}});
    rows.push_back('{CMIN, CMAX, 1, 1, '{CMIN, CMAX, 1, 0}});
    rows.push_back('{CMAX, CMAX, 1, 1, '{CMAX, CMAX, 1, 0}});
    rows.push_back('{CMIN, CMIN, 1, 1, '{CMIN, CMIN, 1, 0}});
    rows.push_back('{-30'sd1, 30'sd1, 1, 1, '{-30'sd1, 30'sd1, 1, 0}});
    // equal distances around home, swaps reorder later ties
    rows.push_back('{30'sd1, '0, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{'0, 30'sd1, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{-30'sd1, '0, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{'0, -30'sd1, 1, 0, '{'0, '0, 0, 0}});
    // duplicate points and ties along a diagonal
    rows.push_back('{30'sd2, 30'sd2, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{30'sd5, 30'sd5, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{30'sd3, 30'sd3, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{-30'sd2, -30'sd2, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{30'sd2, 30'sd2, 1, 0, '{'0, '0, 0, 0}});
    // widest distances
    rows.push_back('{CMIN, CMIN, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{CMAX, CMAX, 0, 0, '{'0, '0, 0, 0}});
    rows.push_back('{'0, '0, 1, 0, '{'0, '0, 0, 0}});

    // typed rows queue their visit before the beat goes out
    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed) visit_q.push_back(r.want);
      send_point(r.x, r.y, r.last, !r.typed);
    end
    drain();

    // random phases, each under its own home point
    phase = 0;
    while (n_items < 250) begin
      case (phase % 6)
        0: set_home(CMAX, CMAX);
        1: set_home(CMIN, CMIN);
        2: set_home(CMIN, CMAX);
        3: set_home('0, '0);
        default: set_home(coord_t'($urandom), coord_t'($urandom));
      endcase
      if (phase == 1)
        send_set(NPTS, $urandom_range(0, 2));
      else if (phase == 3)
        send_set(NPTS + $urandom_range(1, 3), $urandom_range(0, 2));
      repeat ($urandom_range(3, 6))
        send_set($urandom_range(0, 7) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 8),
                 $urandom_range(0, 2));
      drain();
      phase++;
    end

    $display("%0d points in %0d sets (%0d with overflow), %0d ordered beats checked",
             n_items, n_sets, n_ovf_sets, n_visits);
    if (n_err == 0)
      $display("[nearest_neighbor_point_order_core] OK");
    else
      $display("[nearest_neighbor_point_order_core] ERROR");
    $finish;
  end

endmodule
